### hw/rtl/tks_pkg.sv
// Shared constants and types for the top-k selector.
package tks_pkg;

  localparam int MAX_K_DEFAULT = 16;
  localparam int POSITION_BITS_DEFAULT = 20;
  localparam int SCORE_BITS_DEFAULT = 32;

  localparam int KEEP_BITS = 5;
  localparam logic [KEEP_BITS-1:0] KEEP_RESET = 5'd16;

  typedef struct packed {
    logic step;
    logic last;
  } list_ctrl_t;

endpackage

### hw/rtl/tks_list.sv
// Sorted list of kept entries with a parallel compare-and-shift insert.
module tks_list #(
  parameter int MAX_K = tks_pkg::MAX_K_DEFAULT,
  parameter int POSITION_BITS = tks_pkg::POSITION_BITS_DEFAULT,
  parameter int SCORE_BITS = tks_pkg::SCORE_BITS_DEFAULT,
  localparam int FILL_BITS = $clog2(MAX_K + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tks_pkg::list_ctrl_t                  ctrl,
  input  logic signed [SCORE_BITS-1:0]         score,
  input  logic [POSITION_BITS-1:0]             pos,
  input  logic [tks_pkg::KEEP_BITS-1:0]        keep_count,
  output logic signed [SCORE_BITS-1:0]         snap_val [MAX_K],
  output logic [POSITION_BITS-1:0]             snap_pos [MAX_K],
  output logic [FILL_BITS-1:0]                 snap_count
);

  logic signed [SCORE_BITS-1:0] list_val [MAX_K];
  logic [POSITION_BITS-1:0]     list_pos [MAX_K];
  logic [FILL_BITS-1:0]         fill;

  logic signed [SCORE_BITS-1:0] sh_val [MAX_K];
  logic [POSITION_BITS-1:0]     sh_pos [MAX_K];
  logic [MAX_K-1:0]             lt;
  logic [MAX_K-1:0]             tail;
  logic [MAX_K-1:0]             ahead;
  logic [MAX_K-1:0]             prev;
  logic [FILL_BITS-1:0]         eff_k;
  logic [FILL_BITS-1:0]         count;
  logic [FILL_BITS-1:0]         fill_next;
  logic                         tail_lt;
  logic                         grow;
  logic                         do_ins;

  always_comb begin
    if (32'(keep_count) > 32'(MAX_K)) begin
      eff_k = FILL_BITS'(MAX_K);
    end else begin
      eff_k = FILL_BITS'(keep_count);
    end

    for (int i = 0; i < MAX_K; i++) begin
      lt[i] = list_val[i] < score;
      tail[i] = fill == FILL_BITS'(i + 1);
    end
    tail_lt = |(lt & tail);
    grow = fill < eff_k;
    do_ins = grow || ((fill != '0) && tail_lt);
    count = grow ? fill : fill - FILL_BITS'(1);
    fill_next = grow ? fill + FILL_BITS'(1) : fill;

    for (int i = 0; i < MAX_K; i++) begin
      ahead[i] = (FILL_BITS'(i) < count) && !lt[i];
    end

    sh_val[0] = score;
    sh_pos[0] = pos;
    prev[0] = 1'b1;
    for (int i = 1; i < MAX_K; i++) begin
      sh_val[i] = list_val[i-1];
      sh_pos[i] = list_pos[i-1];
      prev[i] = ahead[i-1];
    end

    for (int i = 0; i < MAX_K; i++) begin
      snap_val[i] = list_val[i];
      snap_pos[i] = list_pos[i];
      if (do_ins && !ahead[i]) begin
        snap_val[i] = prev[i] ? score : sh_val[i];
        snap_pos[i] = prev[i] ? pos : sh_pos[i];
      end
    end
    snap_count = fill_next;
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      list_val <= snap_val;
      list_pos <= snap_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.step) begin
      fill <= ctrl.last ? '0 : fill_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(MAX_K))
    else $error("fill level exceeds list depth");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    ctrl.step && ctrl.last |=> fill == '0)
    else $error("list not cleared after last beat");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !ctrl.step |=> $stable(fill))
    else $error("fill level changed without a step");

endmodule

### hw/rtl/tks_report.sv
// Report buffer that drains a snapshot of the kept list one beat per cycle while out_ready is high.
module tks_report #(
  parameter int MAX_K = tks_pkg::MAX_K_DEFAULT,
  parameter int POSITION_BITS = tks_pkg::POSITION_BITS_DEFAULT,
  parameter int SCORE_BITS = tks_pkg::SCORE_BITS_DEFAULT,
  localparam int FILL_BITS = $clog2(MAX_K + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic signed [SCORE_BITS-1:0]  load_val [MAX_K],
  input  logic [POSITION_BITS-1:0]      load_pos [MAX_K],
  input  logic [FILL_BITS-1:0]          load_count,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SCORE_BITS-1:0]  kept_score,
  output logic [POSITION_BITS-1:0]      position,
  output logic                          final_result
);

  logic signed [SCORE_BITS-1:0] rep_val [MAX_K];
  logic [POSITION_BITS-1:0]     rep_pos [MAX_K];
  logic [FILL_BITS-1:0]         rep_left;
  logic                         pop;

  assign out_valid = rep_left != '0;
  assign pop = out_valid && out_ready;
  assign free = (rep_left == '0) || ((rep_left == FILL_BITS'(1)) && out_ready);
  assign kept_score = rep_val[0];
  assign position = rep_pos[0];
  assign final_result = rep_left == FILL_BITS'(1);

  always_ff @(posedge clk) begin
    if (load) begin
      rep_val <= load_val;
      rep_pos <= load_pos;
    end else if (pop) begin
      for (int i = 0; i < MAX_K - 1; i++) begin
        rep_val[i] <= rep_val[i+1];
        rep_pos[i] <= rep_pos[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_left <= '0;
    end else if (load) begin
      rep_left <= load_count;
    end else if (pop) begin
      rep_left <= rep_left - FILL_BITS'(1);
    end
  end

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    32'(rep_left) <= 32'(MAX_K))
    else $error("report count exceeds list depth");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("report loaded while a report is still draining");

  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    pop && !final_result && !load |=> out_valid && rep_left == $past(rep_left) - FILL_BITS'(1))
    else $error("report count did not step down after a beat");

endmodule

### hw/rtl/top_k_selector.sv
// Top level of the streaming top-k selector.
// Accepts one score per cycle unless stalled and keeps the k largest (score, position)
// pairs, where k is min(keep_count, MAX_K). A score marked last_item is inserted first,
// then the kept list is copied into a report buffer and the list clears; the report leaves
// as one beat per kept entry, largest first, equal scores in arrival order, with
// final_result on the last beat. A report with no kept entries sends no beat. The first
// report beat is valid once the report buffer is loaded. Input is stalled only when a
// last-marked score reaches the list while the previous report is still draining.
module top_k_selector #(
  parameter int MAX_K = tks_pkg::MAX_K_DEFAULT,
  parameter int POSITION_BITS = tks_pkg::POSITION_BITS_DEFAULT,
  parameter int SCORE_BITS = tks_pkg::SCORE_BITS_DEFAULT,
  localparam int FILL_BITS = $clog2(MAX_K + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tks_pkg::KEEP_BITS-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SCORE_BITS-1:0]         score,
  input  logic                                 last_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SCORE_BITS-1:0]         kept_score,
  output logic [POSITION_BITS-1:0]             position,
  output logic                                 final_result
);

  logic [tks_pkg::KEEP_BITS-1:0] keep_count;
  logic [POSITION_BITS-1:0]      item_counter;

  logic                          ir_valid;
  logic signed [SCORE_BITS-1:0]  ir_score;
  logic                          ir_last;
  logic [POSITION_BITS-1:0]      ir_pos;

  logic                          advance;
  logic                          accept;
  logic                          rep_free;
  tks_pkg::list_ctrl_t           list_ctrl;

  logic signed [SCORE_BITS-1:0]  snap_val [MAX_K];
  logic [POSITION_BITS-1:0]      snap_pos [MAX_K];
  logic [FILL_BITS-1:0]          snap_count;

  assign advance = ir_valid && (!ir_last || rep_free);
  assign in_ready = !ir_valid || advance;
  assign accept = in_valid && in_ready;
  assign list_ctrl.step = advance;
  assign list_ctrl.last = ir_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= tks_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      keep_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
      item_counter <= '0;
    end else begin
      if (accept) begin
        ir_valid <= 1'b1;
        item_counter <= last_item ? '0 : item_counter + POSITION_BITS'(1);
      end else if (advance) begin
        ir_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_score <= score;
      ir_last <= last_item;
      ir_pos <= item_counter;
    end
  end

  tks_list #(
    .MAX_K(MAX_K),
    .POSITION_BITS(POSITION_BITS),
    .SCORE_BITS(SCORE_BITS)
  ) u_list (
    .clk(clk),
    .rst(rst),
    .ctrl(list_ctrl),
    .score(ir_score),
    .pos(ir_pos),
    .keep_count(keep_count),
    .snap_val(snap_val),
    .snap_pos(snap_pos),
    .snap_count(snap_count)
  );

  tks_report #(
    .MAX_K(MAX_K),
    .POSITION_BITS(POSITION_BITS),
    .SCORE_BITS(SCORE_BITS)
  ) u_report (
    .clk(clk),
    .rst(rst),
    .load(advance && ir_last),
    .load_val(snap_val),
    .load_pos(snap_pos),
    .load_count(snap_count),
    .free(rep_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kept_score(kept_score),
    .position(position),
    .final_result(final_result)
  );

endmodule

### tb/sv/top_k_selector_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the top-k selector: a ranking predictor checks every report beat.
module top_k_selector_test;

  localparam int SW = tks_pkg::SCORE_BITS_DEFAULT;
  localparam int PW = tks_pkg::POSITION_BITS_DEFAULT;
  localparam int KMAX = tks_pkg::MAX_K_DEFAULT;
  localparam int KB = tks_pkg::KEEP_BITS;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 19;
  localparam int RANDOM_ITEMS = 360;
  localparam int MIN_PHASES = 7;
  localparam logic signed [SW-1:0] SCORE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SCORE_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct {
    logic signed [SW-1:0] value;
    logic [PW-1:0]        pos;
    logic                 final_flag;
  } ranked_entry_t;

  class ranking_tracker;
    logic [KB-1:0]        keep_count;
    logic signed [SW-1:0] kept_values[KMAX];
    logic [PW-1:0]        kept_pos[KMAX];
    int                   fill_level;
    logic [PW-1:0]        next_pos;
    ranked_entry_t        expected_ranking[$];
    int                   errors;

    function new();
      keep_count = tks_pkg::KEEP_RESET;
      fill_level = 0;
      next_pos = '0;
      errors = 0;
    endfunction

    function void set_keep(logic [KB-1:0] v);
      keep_count = v;
    endfunction

    // Equal scores stay in arrival order: a new entry goes before the first strictly smaller one.
    function void insert_entry(int count, logic signed [SW-1:0] v, logic [PW-1:0] p);
      int slot;
      slot = count;
      for (int i = 0; i < count; i++) begin
        if (kept_values[i] < v) begin
          slot = i;
          break;
        end
      end
      for (int i = count; i > slot; i--) begin
        kept_values[i] = kept_values[i-1];
        kept_pos[i] = kept_pos[i-1];
      end
      kept_values[slot] = v;
      kept_pos[slot] = p;
    endfunction

    function void note_score(logic signed [SW-1:0] v, logic is_last);
      int k;
      ranked_entry_t e;
      k = (keep_count > KMAX) ? KMAX : int'(keep_count);
      if (fill_level < k) begin
        insert_entry(fill_level, v, next_pos);
        fill_level++;
      end else if (fill_level > 0 && v > kept_values[fill_level-1]) begin
        insert_entry(fill_level - 1, v, next_pos);
      end
      next_pos++;
      if (is_last) begin
        for (int i = 0; i < fill_level; i++) begin
          e.value = kept_values[i];
          e.pos = kept_pos[i];
          e.final_flag = (i == fill_level - 1);
          expected_ranking.push_back(e);
        end
        fill_level = 0;
        next_pos = '0;
      end
    endfunction

    function void mismatch(string field, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
    endfunction

    function void check_ranked(logic signed [SW-1:0] v, logic [PW-1:0] p, logic f);
      ranked_entry_t e;
      if (expected_ranking.size() == 0) begin
        errors++;
        $display("%0t: result beat expected none, got kept_score %0d position %0d",
                 $time, v, p);
      end else begin
        e = expected_ranking.pop_front();
        if (v !== e.value) mismatch("kept_score", longint'(e.value), longint'(v));
        if (p !== e.pos) mismatch("position", longint'(e.pos), longint'(p));
        if (f !== e.final_flag) mismatch("final_result", longint'(e.final_flag), longint'(f));
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [KB-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] score = '0;
  logic                 last_item = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] kept_score;
  logic [PW-1:0]        position;
  logic                 final_result;

  bit             no_gaps = 1'b0;
  bit             hold_off_go = 1'b0;
  int             cycle_count = 0;
  ranking_tracker tracker = new();

  top_k_selector u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .score        (score),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kept_score   (kept_score),
    .position     (position),
    .final_result (final_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_ranked(kept_score, position, final_result);
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_go) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_go = 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic signed [SW-1:0] pick_score();
    case ($urandom_range(3))
      0: return int'($urandom_range(6)) - 3;
      1: begin
        case ($urandom_range(3))
          0: return SCORE_MAX;
          1: return SCORE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_score(logic signed [SW-1:0] v, logic is_last);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    score <= v;
    last_item <= is_last;
    do @(posedge clk); while (!in_ready);
    tracker.note_score(v, is_last);
    @(negedge clk);
  endtask

  task automatic send_stream(int len);
    for (int n = 0; n < len; n++) send_score(pick_score(), n == len - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.expected_ranking.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_keep(logic [KB-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_keep(v);
  endtask

  initial begin
    int sent;
    int phase;
    int run_len;
    logic [KB-1:0] kc;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A keep count above the list size saturates; the seventeenth score finds the list full.
    write_keep(5'd31);
    send_score(SCORE_MAX, 1'b0);
    send_score(SCORE_MIN, 1'b0);
    send_score('0, 1'b0);
    send_score('1, 1'b0);
    for (int n = 0; n < 13; n++) send_score(pick_score(), n == 12);

    wait_idle();
    write_keep(5'd1);
    send_score(7, 1'b0);
    send_score(9, 1'b1);

    // Ties: the latest of the equal smallest entries is displaced, and an equal score never enters.
    wait_idle();
    write_keep(5'd3);
    send_score(4, 1'b0);
    send_score(4, 1'b0);
    send_score(4, 1'b0);
    send_score(9, 1'b0);
    send_score(4, 1'b1);

    wait_idle();
    write_keep(5'd0);
    send_score(7, 1'b0);
    send_score(-7, 1'b1);

    // Lowering the keep count in the middle of a stream keeps what is already held.
    wait_idle();
    write_keep(5'd4);
    for (int n = 0; n < 4; n++) send_score(pick_score(), 1'b0);
    wait_idle();
    write_keep(5'd2);
    send_score(pick_score(), 1'b0);
    send_score(pick_score(), 1'b1);
    wait_idle();
    send_score(-5, 1'b1);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS || phase < MIN_PHASES) begin
      wait_idle();
      case ($urandom_range(9))
        0: kc = '0;
        1: kc = KB'($urandom_range(31, KMAX + 1));
        2: kc = 5'd1;
        3: kc = KB'(KMAX);
        default: kc = KB'($urandom_range(KMAX, 1));
      endcase
      if (phase == 3) kc = KB'(KMAX);
      write_keep(kc);
      no_gaps = (phase == 3) || (phase == 6);
      if (phase == 3) begin
        // The receiver holds off while short reports pile up behind each other.
        hold_off_go = 1'b1;
        repeat (8) begin
          send_stream(3);
          sent += 3;
        end
      end else begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(9) == 0) begin
            run_len = int'($urandom_range(40, KMAX + 1));
          end else begin
            run_len = int'($urandom_range(12, 1));
          end
          send_stream(run_len);
          sent += run_len;
        end
      end
      phase++;
    end
    no_gaps = 1'b0;

    wait_idle();
    repeat (20) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
